// ===== hdl/query_expression_tokenizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// query_expression_tokenizer_core_macros
// Assertion helpers used by the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef QUERY_EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define QUERY_EXPRESSION_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QET_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QET_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== hdl/qet_pkg.sv =====
// ----------------------------------------------------------------------------
// qet_pkg
// Types, token codes and character classes for the query tokenizer.
// ----------------------------------------------------------------------------
package qet_pkg;

    localparam int MAX_RESULTS = 6;

    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_COMMENT  = 4'd1,
        M_NUM_INT  = 4'd2,
        M_NUM_FRAC = 4'd3,
        M_NUM_EXPS = 4'd4,
        M_NUM_EXP  = 4'd5,
        M_STRING   = 4'd6,
        M_STR_ESC  = 4'd7,
        M_IDENT    = 4'd8,
        M_OP2      = 4'd9,
        M_HALT     = 4'd10
    } mode_t;

    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_ERROR   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_IDENT   = 6'd4;
    localparam logic [5:0] OP_EQEQ   = 6'd11;
    localparam logic [5:0] OP_NE     = 6'd12;
    localparam logic [5:0] OP_LE     = 6'd13;
    localparam logic [5:0] OP_GE     = 6'd14;
    localparam logic [5:0] OP_ALTEQ  = 6'd15;
    localparam logic [5:0] OP_ADDEQ  = 6'd16;
    localparam logic [5:0] OP_ALT2   = 6'd17;
    localparam logic [5:0] OP_DOTDOT = 6'd18;
    localparam logic [5:0] OP_SINGLE = 6'd19;

    localparam logic [3:0] KW_NONE    = 4'd0;
    localparam logic [3:0] KW_TRUE    = 4'd1;
    localparam logic [3:0] KW_FALSE   = 4'd2;
    localparam logic [3:0] KW_NULL    = 4'd3;
    localparam logic [3:0] KW_AND     = 4'd4;
    localparam logic [3:0] KW_OR      = 4'd5;
    localparam logic [3:0] KW_NOT     = 4'd6;
    localparam logic [3:0] KW_NPREFIX = 4'd7;

    typedef struct packed {
        logic        rec;
        logic [7:0]  val;
        logic [5:0]  kind;
        logic [15:0] ln;
        logic [15:0] col;
        logic        last;
    } rec_t;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == "$";
    endfunction

    // Keyword length by match code; zero for no keyword.
    function automatic logic [2:0] kw_len(logic [3:0] km);
        logic [2:0] r;
        case (km)
            KW_TRUE:  r = 3'd4;
            KW_FALSE: r = 3'd5;
            KW_NULL:  r = 3'd4;
            KW_AND:   r = 3'd3;
            KW_OR:    r = 3'd2;
            KW_NOT:   r = 3'd3;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(logic [3:0] km, logic [2:0] pos);
        logic [39:0] s;
        case (km)
            KW_TRUE:  s = {8'h0, "eurt"};
            KW_FALSE: s = "eslaf";
            KW_NULL:  s = {8'h0, "llun"};
            KW_AND:   s = {16'h0, "dna"};
            KW_OR:    s = {24'h0, "ro"};
            KW_NOT:   s = {16'h0, "ton"};
            default:  s = '0;
        endcase
        return (pos < 3'd5) ? s[pos*8 +: 8] : 8'h0;
    endfunction

    function automatic logic [5:0] pair_kind(logic [7:0] c, logic [7:0] pk);
        logic [5:0] r;
        r = K_END;
        if (pk == "=") begin
            case (c)
                "=":     r = OP_EQEQ;
                "!":     r = OP_NE;
                "<":     r = OP_LE;
                ">":     r = OP_GE;
                "|":     r = OP_ALTEQ;
                "+":     r = OP_ADDEQ;
                default: r = K_END;
            endcase
        end else if (c == "/" && pk == "/") begin
            r = OP_ALT2;
        end else if (c == "." && pk == ".") begin
            r = OP_DOTDOT;
        end
        return r;
    endfunction

    function automatic logic [5:0] single_kind(logic [7:0] c);
        logic [5:0] off;
        logic       hit;
        hit = 1'b1;
        case (c)
            ".":     off = 6'd0;
            "|":     off = 6'd1;
            ",":     off = 6'd2;
            ";":     off = 6'd3;
            ":":     off = 6'd4;
            "+":     off = 6'd5;
            "-":     off = 6'd6;
            "*":     off = 6'd7;
            "/":     off = 6'd8;
            "%":     off = 6'd9;
            "=":     off = 6'd10;
            "<":     off = 6'd11;
            ">":     off = 6'd12;
            "(":     off = 6'd13;
            ")":     off = 6'd14;
            "[":     off = 6'd15;
            "]":     off = 6'd16;
            "{":     off = 6'd17;
            "}":     off = 6'd18;
            "?":     off = 6'd19;
            default: begin
                off = 6'd0;
                hit = 1'b0;
            end
        endcase
        return hit ? OP_SINGLE + off : K_END;
    endfunction

endpackage

// ===== hdl/query_expression_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// query_expression_tokenizer_core
// Streaming lexer for query text: bytes in, token text and end records out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one text byte per item (tdata[7:0]); s_tlast marks the
//   final byte of a text. A zero byte also ends the text; later bytes up to
//   s_tlast are dropped, and s_tlast restarts the lexer from its reset state.
//   m_ channel carries result items: tuser is the record kind (0 text byte,
//   1 token end), tdata holds value, token kind, start line and start column,
//   and m_tlast flags the last result caused by one input item.
//   One byte of lookahead is held, so a byte's results come out when the next
//   byte (or the end of text) is accepted.
//   Latency: results of an accepted item appear on m_ the next cycle.
//   Throughput: one input item per cycle while each yields at most one result
//   and m_tready is high; an item with more results holds the result buffer
//   while it drains one record per cycle through a single output port.
//   A new item is taken while the last buffered result is being handed over.
//   Reset (aresetn low, synchronous) clears the lexer state and the buffer.
//   When m_tready is low, the current result holds and input is held off
//   while any result is left in the buffer.
// ----------------------------------------------------------------------------
module query_expression_tokenizer_core
    import qet_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] value_byte, [13:8] token_kind,
                                   // [29:14] begin_line, [45:30] start_column
    output logic        m_tuser,   // record_kind
    output logic        m_tlast    // run_last
);

`include "query_expression_tokenizer_core_macros.svh"

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [2:0]             RES_MAX  = 3'(MAX_RESULTS);

    typedef struct packed {
        logic [7:0]             la_byte;
        logic                   la_valid;
        mode_t                  mode;
        logic [3:0]             kw;
        logic [2:0]             ilen;
        logic [5:0]             pend;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LINE_BITS-1:0]   tline;
        logic [COLUMN_BITS-1:0] tcol;
    } st_t;

    typedef struct packed {
        st_t                          st;
        rec_t [MAX_RESULTS-1:0]       list;
        logic [2:0]                   n;
    } work_t;

    localparam st_t ST_RESET = '{
        la_byte: 8'h0, la_valid: 1'b0, mode: M_IDLE, kw: KW_NONE, ilen: 3'd0,
        pend: K_END, line: LINE_ONE, col: COL_ONE, tline: LINE_ONE, tcol: COL_ONE
    };

    // Append one record; drop anything past the buffer depth.
    function automatic work_t emit(work_t w, logic rec, logic [7:0] val,
                                   logic [5:0] kind, logic [15:0] ln,
                                   logic [15:0] col);
        work_t r;
        r = w;
        if (r.n < RES_MAX) begin
            r.list[r.n] = '{rec: rec, val: val, kind: kind, ln: ln, col: col,
                            last: 1'b0};
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t emit_text(work_t w, logic [7:0] c);
        return emit(w, 1'b0, c, K_END, 16'(w.st.tline), 16'(w.st.tcol));
    endfunction

    function automatic work_t emit_end(work_t w, logic [5:0] k);
        return emit(w, 1'b1, 8'h0, k, 16'(w.st.tline), 16'(w.st.tcol));
    endfunction

    // Advance line/column, saturating at the counter maximum.
    function automatic work_t move_pos(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (c == 8'h0a) begin
            if (r.st.line != LINE_MAX) r.st.line = r.st.line + LINE_ONE;
            r.st.col = COL_ONE;
        end else if (r.st.col != COL_MAX) begin
            r.st.col = r.st.col + COL_ONE;
        end
        return r;
    endfunction

    function automatic work_t kw_track(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (r.st.ilen == 3'd0) begin
            case (c)
                "t":     r.st.kw = KW_TRUE;
                "f":     r.st.kw = KW_FALSE;
                "n":     r.st.kw = KW_NPREFIX;
                "a":     r.st.kw = KW_AND;
                "o":     r.st.kw = KW_OR;
                default: r.st.kw = KW_NONE;
            endcase
        end else if (r.st.kw == KW_NPREFIX) begin
            r.st.kw = (c == "u") ? KW_NULL : (c == "o") ? KW_NOT : KW_NONE;
        end else if (r.st.kw != KW_NONE) begin
            if (!(r.st.ilen < kw_len(r.st.kw) && kw_char(r.st.kw, r.st.ilen) == c))
                r.st.kw = KW_NONE;
        end
        if (r.st.ilen != 3'd7) r.st.ilen = r.st.ilen + 3'd1;
        return r;
    endfunction

    function automatic work_t close_token(work_t w);
        work_t r;
        r = w;
        case (r.st.mode)
            M_NUM_INT, M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXP: r = emit_end(r, K_NUMBER);
            M_STRING, M_STR_ESC: r = emit_end(r, K_STRING);
            M_IDENT: begin
                if (r.st.kw != KW_NONE && r.st.kw != KW_NPREFIX &&
                    r.st.ilen == kw_len(r.st.kw))
                    r = emit_end(r, K_IDENT + {2'b00, r.st.kw});
                else
                    r = emit_end(r, K_IDENT);
            end
            M_OP2:   r = emit_end(r, r.st.pend);
            default: ;
        endcase
        r.st.mode = M_IDLE;
        return r;
    endfunction

    function automatic work_t scan_idle(work_t w, logic [7:0] c, logic [7:0] pk);
        work_t      r;
        logic [5:0] pkind;
        logic [5:0] skind;
        r     = w;
        pkind = pair_kind(c, pk);
        skind = single_kind(c);
        if (is_space(c)) begin
            r = move_pos(r, c);
        end else if (c == "#") begin
            r.st.mode = M_COMMENT;
            r = move_pos(r, c);
        end else begin
            r.st.tline = r.st.line;
            r.st.tcol  = r.st.col;
            if (is_digit(c) || (c == "-" && is_digit(pk))) begin
                r = emit_text(r, c);
                r.st.mode = M_NUM_INT;
            end else if (c == "\"") begin
                r.st.mode = M_STRING;
            end else if (is_alpha(c) || c == "_" || c == "$") begin
                r.st.ilen = 3'd0;
                r.st.kw   = KW_NONE;
                r = kw_track(r, c);
                r = emit_text(r, c);
                r.st.mode = M_IDENT;
            end else if (pkind != K_END) begin
                r = emit_text(r, c);
                r.st.pend = pkind;
                r.st.mode = M_OP2;
            end else if (skind != K_END) begin
                r = emit_text(r, c);
                r = emit_end(r, skind);
            end else begin
                // Unknown byte: error token, then ignore input to the last flag.
                r = emit_text(r, c);
                r = emit_end(r, K_ERROR);
                r.st.mode     = M_HALT;
                r.st.la_valid = 1'b0;
            end
            r = move_pos(r, c);
        end
        return r;
    endfunction

    function automatic work_t scan_byte(work_t w, logic [7:0] c, logic [7:0] pk);
        work_t      r;
        logic       done;
        logic [7:0] d;
        r    = w;
        done = 1'b1;
        case (r.st.mode)
            M_HALT: ;
            M_COMMENT: begin
                if (c != 8'h0a) r = move_pos(r, c);
                else begin
                    r.st.mode = M_IDLE;
                    done = 1'b0;
                end
            end
            M_NUM_INT: begin
                if (is_digit(c)) begin
                    r = emit_text(r, c);
                    r = move_pos(r, c);
                end else if (c == "." || c == "e" || c == "E") begin
                    r = emit_text(r, c);
                    r.st.mode = (c == ".") ? M_NUM_FRAC : M_NUM_EXPS;
                    r = move_pos(r, c);
                end else begin
                    r = close_token(r);
                    done = 1'b0;
                end
            end
            M_NUM_FRAC: begin
                if (is_digit(c) || c == "e" || c == "E") begin
                    r = emit_text(r, c);
                    if (!is_digit(c)) r.st.mode = M_NUM_EXPS;
                    r = move_pos(r, c);
                end else begin
                    r = close_token(r);
                    done = 1'b0;
                end
            end
            M_NUM_EXPS: begin
                if (is_digit(c) || c == "+" || c == "-") begin
                    r = emit_text(r, c);
                    r.st.mode = M_NUM_EXP;
                    r = move_pos(r, c);
                end else begin
                    r = close_token(r);
                    done = 1'b0;
                end
            end
            M_NUM_EXP: begin
                if (is_digit(c)) begin
                    r = emit_text(r, c);
                    r = move_pos(r, c);
                end else begin
                    r = close_token(r);
                    done = 1'b0;
                end
            end
            M_STRING: begin
                if (c == "\"") r = close_token(r);
                else if (c == "\\") r.st.mode = M_STR_ESC;
                else r = emit_text(r, c);
                r = move_pos(r, c);
            end
            M_STR_ESC: begin
                case (c)
                    "n":     d = 8'd10;
                    "t":     d = 8'd9;
                    "r":     d = 8'd13;
                    "b":     d = 8'd8;
                    "f":     d = 8'd12;
                    default: d = c;
                endcase
                r = emit_text(r, d);
                r.st.mode = M_STRING;
                r = move_pos(r, c);
            end
            M_IDENT: begin
                if (is_ident(c)) begin
                    r = kw_track(r, c);
                    r = emit_text(r, c);
                    r = move_pos(r, c);
                end else begin
                    r = close_token(r);
                    done = 1'b0;
                end
            end
            M_OP2: begin
                r = emit_text(r, c);
                r = emit_end(r, r.st.pend);
                r.st.mode = M_IDLE;
                r = move_pos(r, c);
            end
            default: begin
                r.st.mode = M_IDLE;
                done = 1'b0;
            end
        endcase
        if (!done) r = scan_idle(r, c, pk);
        return r;
    endfunction

    // Close any open token and emit the end-of-text record.
    function automatic work_t finish_text(work_t w);
        work_t r;
        r = w;
        if (r.st.mode != M_HALT) begin
            r = close_token(r);
            r = emit(r, 1'b1, 8'h0, K_END, 16'(r.st.line), 16'(r.st.col));
            r.st.mode     = M_HALT;
            r.st.la_valid = 1'b0;
        end
        return r;
    endfunction

    st_t                    st_reg;
    rec_t [MAX_RESULTS-1:0] list_reg;
    logic [2:0]             cnt_reg;
    logic [2:0]             rd_reg;
    logic [2:0]             rd_inc;
    work_t                  w_next;
    logic                   in_fire;
    logic                   out_fire;
    rec_t                   cur;

    // Work out every result of the offered byte in one pass.
    always_comb begin
        w_next      = '0;
        w_next.st   = st_reg;
        w_next.list = '0;
        w_next.n    = 3'd0;
        if (st_reg.mode != M_HALT) begin
            if (s_tdata == 8'h0) begin
                if (st_reg.la_valid) w_next = scan_byte(w_next, st_reg.la_byte, 8'h0);
                w_next.st.la_valid = 1'b0;
                w_next = finish_text(w_next);
            end else begin
                if (st_reg.la_valid) w_next = scan_byte(w_next, st_reg.la_byte, s_tdata);
                if (w_next.st.mode != M_HALT) begin
                    w_next.st.la_byte  = s_tdata;
                    w_next.st.la_valid = 1'b1;
                    if (s_tlast) begin
                        w_next.st.la_valid = 1'b0;
                        w_next = scan_byte(w_next, s_tdata, 8'h0);
                        w_next = finish_text(w_next);
                    end
                end
            end
        end
        if (s_tlast) w_next.st = ST_RESET;
        if (w_next.n != 3'd0) w_next.list[w_next.n - 3'd1].last = 1'b1;
    end

    assign rd_inc   = rd_reg + 3'd1;
    assign m_tvalid = rd_reg != cnt_reg;
    assign out_fire = m_tvalid && m_tready;
    // Take a new byte once the buffer is empty or handing over its last record.
    assign s_tready = !m_tvalid || (rd_inc == cnt_reg && m_tready);
    assign in_fire  = s_tvalid && s_tready;

    assign cur     = list_reg[rd_reg];
    assign m_tdata = {2'b00, cur.col, cur.ln, cur.kind, cur.val};
    assign m_tuser = cur.rec;
    assign m_tlast = cur.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_RESET;
            cnt_reg <= 3'd0;
            rd_reg  <= 3'd0;
        end else if (in_fire) begin
            st_reg  <= w_next.st;
            cnt_reg <= w_next.n;
            rd_reg  <= 3'd0;
        end else if (out_fire) begin
            rd_reg  <= rd_inc;
        end
    end

    // Payload buffer: load the whole result list with the item.
    always_ff @(posedge aclk) begin
        if (in_fire) list_reg <= w_next.list;
    end

    `QET_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `QET_ASSERT_NOW(a_count_bounded, aclk, aresetn, 1'b1, cnt_reg <= RES_MAX && rd_reg <= cnt_reg)
    `QET_ASSERT_NEXT(a_load_restarts, aclk, aresetn, in_fire, rd_reg == 3'd0)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the query tokenizer: streams texts byte by byte,
// predicts every text and end record in a behavioral lexer model, and
// compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import qet_pkg::*;

    localparam logic [5:0] KIND_TRUE = 6'd5;
    localparam int MAX_CYCLES = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    query_expression_tokenizer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---- lexer model state ----
    logic [7:0]  la_byte;
    logic        la_valid;
    mode_t       lex_mode;
    logic [3:0]  kw_hit;
    logic [2:0]  id_len;
    logic [5:0]  op_pending;
    logic [15:0] cur_line, cur_col, tok_ln, tok_col;

    rec_t expected_recs[$];
    rec_t step_recs[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_left = 0;

    function automatic logic dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic white(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic word_char(logic [7:0] c);
        return alpha(c) || dig(c) || c == "_" || c == "$";
    endfunction

    function automatic int kw_length(logic [3:0] k);
        case (k)
            KW_TRUE, KW_NULL: return 4;
            KW_FALSE:         return 5;
            KW_AND, KW_NOT:   return 3;
            KW_OR:            return 2;
            default:          return 0;
        endcase
    endfunction

    function automatic logic [7:0] kw_letter(logic [3:0] k, int pos);
        string s;
        case (k)
            KW_TRUE:  s = "true";
            KW_FALSE: s = "false";
            KW_NULL:  s = "null";
            KW_AND:   s = "and";
            KW_OR:    s = "or";
            KW_NOT:   s = "not";
            default:  s = "";
        endcase
        return (pos < s.len()) ? s[pos] : 8'd0;
    endfunction

    function automatic logic [5:0] two_char_kind(logic [7:0] c, logic [7:0] pk);
        if (pk == "=") begin
            case (c)
                "=": return OP_EQEQ;
                "!": return OP_NE;
                "<": return OP_LE;
                ">": return OP_GE;
                "|": return OP_ALTEQ;
                "+": return OP_ADDEQ;
                default: return K_END;
            endcase
        end
        if (c == "/" && pk == "/") return OP_ALT2;
        if (c == "." && pk == ".") return OP_DOTDOT;
        return K_END;
    endfunction

    function automatic logic [5:0] one_char_kind(logic [7:0] c);
        string ops;
        ops = ".|,;:+-*/%=<>()[]{}?";
        for (int i = 0; i < ops.len(); i++)
            if (ops[i] == c) return OP_SINGLE + 6'(i);
        return K_END;
    endfunction

    task automatic push_rec(logic r, logic [7:0] v, logic [5:0] k,
                            logic [15:0] ln, logic [15:0] cl);
        rec_t x;
        x.rec = r; x.val = v; x.kind = k; x.ln = ln; x.col = cl; x.last = 1'b0;
        if (step_recs.size() < MAX_RESULTS) step_recs = {step_recs, x};
    endtask

    task automatic lex_reset();
        la_byte = 0; la_valid = 0; lex_mode = M_IDLE; kw_hit = KW_NONE;
        id_len = 0; op_pending = 0;
        cur_line = 1; cur_col = 1; tok_ln = 1; tok_col = 1;
    endtask

    // saturating position advance
    task automatic advance_pos(logic [7:0] c);
        if (c == 8'h0a) begin
            if (cur_line != 16'hffff) cur_line++;
            cur_col = 1;
        end else if (cur_col != 16'hffff) begin
            cur_col++;
        end
    endtask

    task automatic track_keyword(logic [7:0] c);
        if (id_len == 0) begin
            kw_hit = c == "t" ? KW_TRUE : c == "f" ? KW_FALSE : c == "n" ? KW_NPREFIX :
                     c == "a" ? KW_AND : c == "o" ? KW_OR : KW_NONE;
        end else if (kw_hit == KW_NPREFIX) begin
            kw_hit = c == "u" ? KW_NULL : c == "o" ? KW_NOT : KW_NONE;
        end else if (kw_hit >= KW_TRUE && kw_hit <= KW_NOT) begin
            if (!(id_len < kw_length(kw_hit) && kw_letter(kw_hit, id_len) == c))
                kw_hit = KW_NONE;
        end
        if (id_len < 7) id_len++;
    endtask

    task automatic close_tok();
        case (lex_mode)
            M_NUM_INT, M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXP:
                push_rec(1, 0, K_NUMBER, tok_ln, tok_col);
            M_STRING, M_STR_ESC: push_rec(1, 0, K_STRING, tok_ln, tok_col);
            M_IDENT: begin
                if (kw_hit >= KW_TRUE && kw_hit <= KW_NOT && id_len == kw_length(kw_hit))
                    push_rec(1, 0, KIND_TRUE + 6'(kw_hit) - 6'd1, tok_ln, tok_col);
                else
                    push_rec(1, 0, K_IDENT, tok_ln, tok_col);
            end
            M_OP2: push_rec(1, 0, op_pending, tok_ln, tok_col);
            default: ;
        endcase
        lex_mode = M_IDLE;
    endtask

    task automatic start_token(logic [7:0] c, logic [7:0] pk);
        logic [5:0] k;
        if (white(c)) begin
            advance_pos(c);
            return;
        end
        if (c == "#") begin
            lex_mode = M_COMMENT;
            advance_pos(c);
            return;
        end
        tok_ln = cur_line;
        tok_col = cur_col;
        if (dig(c) || (c == "-" && dig(pk))) begin
            push_rec(0, c, K_END, tok_ln, tok_col);
            lex_mode = M_NUM_INT;
        end else if (c == "\"") begin
            lex_mode = M_STRING;
        end else if (alpha(c) || c == "_" || c == "$") begin
            id_len = 0;
            kw_hit = KW_NONE;
            track_keyword(c);
            push_rec(0, c, K_END, tok_ln, tok_col);
            lex_mode = M_IDENT;
        end else if (two_char_kind(c, pk) != K_END) begin
            push_rec(0, c, K_END, tok_ln, tok_col);
            op_pending = two_char_kind(c, pk);
            lex_mode = M_OP2;
        end else if (one_char_kind(c) != K_END) begin
            k = one_char_kind(c);
            push_rec(0, c, K_END, tok_ln, tok_col);
            push_rec(1, 0, k, tok_ln, tok_col);
        end else begin
            push_rec(0, c, K_END, tok_ln, tok_col);
            push_rec(1, 0, K_ERROR, tok_ln, tok_col);
            lex_mode = M_HALT;
            la_valid = 0;
        end
        advance_pos(c);
    endtask

    task automatic scan_char(logic [7:0] c, logic [7:0] pk);
        logic [7:0] d;
        case (lex_mode)
            M_HALT: return;
            M_COMMENT: begin
                if (c != 8'h0a) begin
                    advance_pos(c);
                    return;
                end
                lex_mode = M_IDLE;
            end
            M_NUM_INT, M_NUM_FRAC: begin
                if (dig(c)) begin
                    push_rec(0, c, K_END, tok_ln, tok_col); advance_pos(c); return;
                end
                if (c == "." && lex_mode == M_NUM_INT) begin
                    push_rec(0, c, K_END, tok_ln, tok_col);
                    lex_mode = M_NUM_FRAC; advance_pos(c); return;
                end
                if (c == "e" || c == "E") begin
                    push_rec(0, c, K_END, tok_ln, tok_col);
                    lex_mode = M_NUM_EXPS; advance_pos(c); return;
                end
                close_tok();
            end
            M_NUM_EXPS: begin
                if (dig(c) || c == "+" || c == "-") begin
                    push_rec(0, c, K_END, tok_ln, tok_col);
                    lex_mode = M_NUM_EXP; advance_pos(c); return;
                end
                close_tok();
            end
            M_NUM_EXP: begin
                if (dig(c)) begin
                    push_rec(0, c, K_END, tok_ln, tok_col); advance_pos(c); return;
                end
                close_tok();
            end
            M_STRING: begin
                if (c == "\"") close_tok();
                else if (c == "\\") lex_mode = M_STR_ESC;
                else push_rec(0, c, K_END, tok_ln, tok_col);
                advance_pos(c);
                return;
            end
            M_STR_ESC: begin
                d = c == "n" ? 8'd10 : c == "t" ? 8'd9 : c == "r" ? 8'd13 :
                    c == "b" ? 8'd8 : c == "f" ? 8'd12 : c;
                push_rec(0, d, K_END, tok_ln, tok_col);
                lex_mode = M_STRING;
                advance_pos(c);
                return;
            end
            M_IDENT: begin
                if (word_char(c)) begin
                    track_keyword(c);
                    push_rec(0, c, K_END, tok_ln, tok_col);
                    advance_pos(c);
                    return;
                end
                close_tok();
            end
            M_OP2: begin
                push_rec(0, c, K_END, tok_ln, tok_col);
                push_rec(1, 0, op_pending, tok_ln, tok_col);
                lex_mode = M_IDLE;
                advance_pos(c);
                return;
            end
            default: lex_mode = M_IDLE;
        endcase
        start_token(c, pk);
    endtask

    task automatic finish_run();
        if (lex_mode == M_HALT) return;
        close_tok();
        push_rec(1, 0, K_END, cur_line, cur_col);
        lex_mode = M_HALT;
        la_valid = 0;
    endtask

    // Predict the records caused by one accepted item and queue them.
    task automatic predict_item(logic [7:0] b, logic last);
        step_recs.delete();
        if (lex_mode != M_HALT) begin
            if (b == 8'd0) begin
                if (la_valid) scan_char(la_byte, 8'd0);
                la_valid = 0;
                finish_run();
            end else begin
                if (la_valid) scan_char(la_byte, b);
                if (lex_mode != M_HALT) begin
                    la_byte = b;
                    la_valid = 1;
                    if (last) begin
                        la_valid = 0;
                        scan_char(b, 8'd0);
                        finish_run();
                    end
                end
            end
        end
        if (last) lex_reset();
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
        expected_recs = {expected_recs, step_recs};
    endtask

    // Send one item: hold valid through bursts, insert random gaps between them.
    task automatic send_byte(logic [7:0] b, logic last);
        if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(b, last);
        if (gap_left > 0) gap_left--;
    endtask

    task automatic send_text(string t, logic terminate);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i], terminate && i == t.len() - 1);
    endtask

    // Drop valid right at the accepting edge so the last item is not taken twice.
    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (expected_recs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: stall at random, with stall-free stretches.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) m_tready <= 1'b0;
        else if (cycles % 400 < 120) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rec = m_tuser; got.val = m_tdata[7:0]; got.kind = m_tdata[13:8];
            got.ln = m_tdata[29:14]; got.col = m_tdata[45:30]; got.last = m_tlast;
            if (expected_recs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_recs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_numbers_and_words();
        send_text("-12.5e+3 1e 7. -x true false null and or not nott tru", 1);
        send_text("abcdefghij_$9 truex", 1);
    endtask

    task automatic test_operators();
        send_text("== != <= >= |= += // .. . | , ; : + - * / % = < > ( ) [ ] { } ?", 1);
    endtask

    task automatic test_strings_comments();
        send_text("\"a\\n\\t\\r\\b\\f\\q\\\"\" # note\n\"open\\", 1);
        send_text("x # dangling", 1);
    endtask

    task automatic test_errors_and_ends();
        send_text("a ! b c", 1);      // lone bang is an error; rest ignored
        send_byte(8'hff, 1'b1);
        send_text("ab", 0);
        send_byte(8'd0, 1'b0);        // zero byte ends the text early
        send_text("zz", 1);
        send_byte(8'd0, 1'b1);
        send_byte(8'h80, 1'b1);
    endtask

    // Exercise line tracking with line feeds and other whitespace.
    task automatic test_positions();
        send_text("\n\n\v\f\r\t  1\n  x", 1);
    endtask

    task automatic test_random_texts();
        string pieces[$];
        string t;
        int n;
        logic [7:0] c;
        pieces = '{"foo", "1.5e-2", "\"s\\n\"", "==", "..", "//", "and", "null",
                   " ", "\n", "# c\n", "(", "]", "-3", "+=", "x_1", "?", "not"};
        n = 0;
        while (n < 20) begin
            t = "";
            repeat ($urandom_range(1, 6)) t = {t, pieces[$urandom_range(0, pieces.size() - 1)]};
            if ($urandom_range(0, 3) == 0) begin
                c = 8'($urandom_range(1, 255));
                t = {t, string'(c)};
            end
            send_text(t, 1);
            n += t.len();
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                n += 2;
            end
        end
        idle_sender();
        drain_results();    // hold off until every prediction has arrived
        repeat (20) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        send_byte(8'd0, 1'b1);
    endtask

    initial begin
        lex_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_numbers_and_words();
        test_operators();
        test_strings_comments();
        test_errors_and_ends();
        test_positions();
        test_random_texts();
        idle_sender();
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_recs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
